// ===== design/gbl_pkg.sv =====
// ----------------------------------------------------------------------------
// gbl_pkg
// Command, status and stream layout constants for the line-feed gap buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package gbl_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_MOVE   = 2'd1;
	localparam logic [1:0] CMD_LENGTH = 2'd2;
	localparam logic [1:0] CMD_SHIFT  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// field widths on the stream ports
	localparam int LINE_W   = 9;
	localparam int POS_W    = 24;
	localparam int DELTA_W  = 17;
	localparam int LEN_W    = 25;
	localparam int STAT_W   = 2;
	localparam int IN_DW    = 56;
	localparam int OUT_DW   = 40;

	typedef logic [LINE_W-1:0] line_t;
	typedef logic [LEN_W-1:0]  len_t;

endpackage

`default_nettype wire

// ===== design/gbl_store.sv =====
// ----------------------------------------------------------------------------
// gbl_store
// Line-feed position store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_store #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/gap_buffer_line_index.sv =====
// Sequence: insert, a full-gap insert and a move or length to a bad index go from S_DEC
// straight to S_FIN; a line length goes through S_LENB, and S_LENC unless it is line zero.
// Move gap and shift walk in S_WALK over the entries moved through the store ports
// (one read and one write per cycle, overlapped) and go straight to S_FIN when nothing moves.
// One request at a time: s_tready is high only while the sequencer is idle.
// Reset (arst_n low) empties the index and opens the gap to CAPACITY; store data is not cleared.
// ----------------------------------------------------------------------------
// gap_buffer_line_index
// Gap buffer of line-feed positions with insert, gap move, length and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_line_index
	import gbl_pkg::*;
#(
	parameter int CAPACITY = 256,
	parameter int POS_BITS = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// line_number[8:0], position[32:9], delta[49:33], zero[55:50]
	input  wire logic [IN_DW-1:0]  s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// length[24:0], status[26:25], gap_line[35:27], zero[39:36]
	output logic [OUT_DW-1:0]      m_tdata
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = ((CNT_W > LINE_W) ? CNT_W : LINE_W) + 1;
	localparam int AW    = ((POS_BITS > DELTA_W) ? POS_BITS : DELTA_W) + 2;
	localparam int LW    = (AW > LEN_W) ? AW : LEN_W;
	localparam int PW    = (POS_BITS > POS_W) ? POS_BITS : POS_W;
	localparam int GW    = (CNT_W > LINE_W) ? CNT_W : LINE_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_LENB = 3'd3;
	localparam logic [2:0] S_LENC = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]                state_q;
	logic [1:0]                cmd_q;
	line_t                     line_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [CNT_W-1:0]          gap_start_q, gap_size_q, line_count_q;
	logic [CNT_W-1:0]          ptr_q, rem_q;
	logic                      down_q, shift_q;
	logic                      pend_s1;
	logic [IDX_W-1:0]          waddr_s1;
	logic [POS_BITS-1:0]       cur_q;
	len_t                      res_len_q;
	logic [STAT_W-1:0]         res_status_q;
	logic                      m_tvalid_q;
	logic [OUT_DW-1:0]         m_tdata_q;

	logic                      mem_we, mem_re;
	logic [IDX_W-1:0]          mem_waddr, mem_raddr;
	logic [POS_BITS-1:0]       mem_wdata, rdata;

	logic [CW-1:0]             line_w, start_w, size_w, count_w, line_m1;
	logic [CW-1:0]             phys_cur, phys_prev;
	logic [CNT_W-1:0]          walk_tgt;
	logic [PW-1:0]             pos_ext;
	logic [POS_BITS-1:0]       pos_mem;

	logic [POS_BITS-1:0]       alu_op;
	logic signed [AW-1:0]      alu_a, alu_b, alu_sum;
	logic [AW-1:0]             alu_lo;
	logic [POS_BITS-1:0]       alu_sat;
	logic [LW-1:0]             len_ext;
	logic [GW-1:0]             gap_ext;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// index arithmetic
	assign line_w    = CW'(line_q);
	assign start_w   = CW'(gap_start_q);
	assign size_w    = CW'(gap_size_q);
	assign count_w   = CW'(line_count_q);
	assign line_m1   = line_w - CW'(1);
	assign phys_cur  = (line_w < start_w) ? line_w : line_w + size_w;
	assign phys_prev = (line_m1 < start_w) ? line_m1 : line_m1 + size_w;
	assign walk_tgt  = shift_q ? ptr_q : (down_q ? ptr_q + gap_size_q : ptr_q - gap_size_q);
	assign pos_ext   = PW'(pos_q);
	assign pos_mem   = pos_ext[POS_BITS-1:0];
	assign gap_ext   = GW'(gap_start_q);

	// shared add/subtract unit: shift entries, line length difference, line zero plus one
	always_comb begin
		alu_op = (state_q == S_LENC) ? cur_q : rdata;
		alu_a  = $signed(AW'(alu_op));
		if (state_q == S_WALK) begin
			alu_b = AW'(delta_q);
		end else if (state_q == S_LENC) begin
			alu_b = -$signed(AW'(rdata));
		end else begin
			alu_b = {{(AW-1){1'b0}}, 1'b1};
		end
		alu_sum = alu_a + alu_b;
		alu_lo  = alu_sum[AW-1] ? '0 : alu_sum;
		alu_sat = (alu_lo > AW'({POS_BITS{1'b1}})) ? {POS_BITS{1'b1}} : alu_lo[POS_BITS-1:0];
		len_ext = LW'(alu_lo);
	end

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = gap_start_q[IDX_W-1:0];
		mem_wdata = pos_mem;
		mem_re    = 1'b0;
		mem_raddr = phys_cur[IDX_W-1:0];
		unique case (state_q)
			S_DEC: begin
				mem_we = (cmd_q == CMD_INSERT) && (gap_size_q != '0);
				mem_re = (cmd_q == CMD_LENGTH) && (line_w < count_w);
			end
			S_WALK: begin
				mem_re    = (rem_q != '0);
				mem_raddr = ptr_q[IDX_W-1:0];
				mem_we    = pend_s1;
				mem_waddr = waddr_s1;
				mem_wdata = shift_q ? alu_sat : rdata;
			end
			S_LENB: begin
				mem_re    = (line_q != '0);
				mem_raddr = phys_prev[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	gbl_store #(
		.DEPTH(CAPACITY),
		.WIDTH(POS_BITS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_INSERT;
			line_q       <= '0;
			pos_q        <= '0;
			delta_q      <= '0;
			gap_start_q  <= '0;
			gap_size_q   <= CNT_W'(CAPACITY);
			line_count_q <= '0;
			ptr_q        <= '0;
			rem_q        <= '0;
			down_q       <= 1'b0;
			shift_q      <= 1'b0;
			pend_s1      <= 1'b0;
			waddr_s1     <= '0;
			cur_q        <= '0;
			res_len_q    <= '0;
			res_status_q <= ST_OK;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// the final state sets or holds the output valid itself
			if (m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						line_q  <= s_tdata[8:0];
						pos_q   <= s_tdata[32:9];
						delta_q <= $signed(s_tdata[49:33]);
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_len_q    <= '0;
					res_status_q <= ST_OK;
					pend_s1      <= 1'b0;
					state_q      <= S_FIN;
					case (cmd_q)
						CMD_INSERT: begin
							if (gap_size_q == '0) begin
								res_status_q <= ST_FULL;
							end else begin
								gap_start_q  <= gap_start_q + CNT_W'(1);
								gap_size_q   <= gap_size_q - CNT_W'(1);
								line_count_q <= line_count_q + CNT_W'(1);
							end
						end
						CMD_MOVE: begin
							shift_q <= 1'b0;
							if (line_w > count_w) begin
								res_status_q <= ST_RANGE;
							end else if (line_w < start_w) begin
								// walk down from the last line before the gap
								ptr_q       <= gap_start_q - CNT_W'(1);
								rem_q       <= CNT_W'(start_w - line_w);
								down_q      <= 1'b1;
								gap_start_q <= CNT_W'(line_w);
								state_q     <= S_WALK;
							end else if (line_w > start_w) begin
								// walk up from the first line after the gap
								ptr_q       <= gap_start_q + gap_size_q;
								rem_q       <= CNT_W'(line_w - start_w);
								down_q      <= 1'b0;
								gap_start_q <= CNT_W'(line_w);
								state_q     <= S_WALK;
							end
						end
						CMD_LENGTH: begin
							if (line_w >= count_w) begin
								res_status_q <= ST_RANGE;
							end else begin
								state_q <= S_LENB;
							end
						end
						default: begin
							ptr_q   <= gap_start_q + gap_size_q;
							rem_q   <= line_count_q - gap_start_q;
							down_q  <= 1'b0;
							shift_q <= 1'b1;
							if (line_count_q != gap_start_q) begin
								state_q <= S_WALK;
							end
						end
					endcase
				end
				S_WALK: begin
					if (rem_q != '0) begin
						ptr_q    <= down_q ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
						rem_q    <= rem_q - CNT_W'(1);
						waddr_s1 <= walk_tgt[IDX_W-1:0];
						pend_s1  <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_LENB: begin
					cur_q <= rdata;
					if (line_q == '0) begin
						res_len_q <= len_ext[LEN_W-1:0];
						state_q   <= S_FIN;
					end else begin
						state_q <= S_LENC;
					end
				end
				S_LENC: begin
					res_len_q <= len_ext[LEN_W-1:0];
					state_q   <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, gap_ext[LINE_W-1:0], res_status_q, res_len_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(line_count_q) + CW'(gap_size_q)) == CW'(CAPACITY))
		else $error("line count and gap size do not add up to capacity");

	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gap_start_q <= line_count_q)
		else $error("gap starts beyond the last line");

	a_pend_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_WALK))
		else $error("pending store write outside a walk");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in work");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && rem_q == '0) |-> pend_s1)
		else $error("walk finished without a final write");
`endif

endmodule

`default_nettype wire
